FILE: design/dtok_pkg.sv
`default_nettype none
package dtok_pkg;

  localparam int MAX_LEN    = 65536;
  localparam int MAX_DELIMS = 4;

  localparam int SET_BYTES  = 4;
  localparam int NUM_DELIMS = (MAX_DELIMS < SET_BYTES) ? MAX_DELIMS : SET_BYTES;

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int LEN_W = IDX_W + 1;

  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 3;
  localparam int SET_W    = 32;
  localparam int START_W  = 16;
  localparam int LENGTH_W = 17;
  localparam int REST_W   = 17;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMS_ABSENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_SET     = 2'd2;

  localparam logic [1:0] MODE_TRIM  = 2'd0;
  localparam logic [1:0] MODE_SPACE = 2'd1;
  localparam logic [1:0] MODE_DELIM = 2'd2;

  typedef struct packed {
    logic       sp;
    logic       hit;
    logic [1:0] mode;
  } class_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

endpackage
`default_nettype wire

FILE: design/dtok_if.sv
`default_nettype none
interface dtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_mark;

  modport source (output valid, output char_in, output end_mark, input ready);
  modport sink (input valid, input char_in, input end_mark, output ready);
endinterface

interface dtok_out_if;
  logic        valid;
  logic        ready;
  logic        token_found;
  logic [15:0] token_start;
  logic [16:0] token_length;
  logic        rest_valid;
  logic [16:0] rest_offset;

  modport source (output valid, output token_found, output token_start, output token_length,
                  output rest_valid, output rest_offset, input ready);
  modport sink (input valid, input token_found, input token_start, input token_length,
                input rest_valid, input rest_offset, output ready);
endinterface
`default_nettype wire

FILE: design/delimiter_tokenizer.sv
// Path: a request with end_mark set goes from the input register through the scan logic
//   into the result register; a result not yet taken can stall it in the input register.
// Throughput: one character per cycle while no end request waits in the input register;
//   an end request waits there only while the previous result has not been taken.
// Reset: synchronous; clears the scan state, both valids, and loads register defaults.
`default_nettype none
module delimiter_tokenizer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dtok_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dtok_pkg::SET_W-1:0]     cfg_data,
  dtok_in_if.sink                             chars,
  dtok_out_if.source                          tokens
);

  logic                        s1_valid;
  logic [dtok_pkg::CHAR_W-1:0] s1_char;
  logic                        s1_end;
  logic                        res_free;
  logic                        advance;
  dtok_pkg::class_t            cls;

  assign advance     = s1_valid && (!s1_end || res_free);
  assign chars.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_char <= chars.char_in;
      s1_end  <= chars.end_mark;
    end
  end

  dtok_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_in   (s1_char),
    .cls       (cls)
  );

  dtok_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .end_mark (s1_end),
    .cls      (cls),
    .res_free (res_free),
    .res      (tokens)
  );

  a_char_never_stalls: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_end) |-> chars.ready)
    else $error("character request stalled");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(tokens.valid) |-> $past(s1_valid && s1_end))
    else $error("result without end request");

  a_no_token_zero: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && !tokens.token_found) |->
      (tokens.token_start == '0 && tokens.token_length == '0))
    else $error("empty token with nonzero fields");

  a_rest_zero: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && !tokens.rest_valid) |-> (tokens.rest_offset == '0))
    else $error("rest offset set without stop");

endmodule
`default_nettype wire

FILE: design/dtok_classify.sv
`default_nettype none
module dtok_classify (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [dtok_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dtok_pkg::SET_W-1:0]           cfg_data,
  input  wire logic [dtok_pkg::CHAR_W-1:0]          char_in,
  output dtok_pkg::class_t                          cls
);

  logic                             delims_absent;
  logic [dtok_pkg::COUNT_W-1:0]     delim_count;
  logic [dtok_pkg::SET_W-1:0]       delim_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      delims_absent <= 1'b1;
      delim_count   <= '0;
      delim_set     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtok_pkg::CFG_DELIMS_ABSENT: delims_absent <= cfg_data[0];
        dtok_pkg::CFG_DELIM_COUNT:   delim_count   <= cfg_data[dtok_pkg::COUNT_W-1:0];
        dtok_pkg::CFG_DELIM_SET:     delim_set     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                        any_hard;
    logic                        hit;
    logic [dtok_pkg::CHAR_W-1:0] b;
    logic                        en;
    any_hard = 1'b0;
    hit      = 1'b0;
    for (int k = 0; k < dtok_pkg::NUM_DELIMS; k++) begin
      b  = delim_set[k*dtok_pkg::CHAR_W +: dtok_pkg::CHAR_W];
      en = (32'(delim_count) > k);
      if (en && !dtok_pkg::is_space(b)) any_hard = 1'b1;
      if (en && (b == char_in)) hit = 1'b1;
    end
    cls.sp  = dtok_pkg::is_space(char_in);
    cls.hit = hit;
    if (delims_absent) begin
      cls.mode = dtok_pkg::MODE_TRIM;
    end else if (any_hard) begin
      cls.mode = dtok_pkg::MODE_DELIM;
    end else begin
      cls.mode = dtok_pkg::MODE_SPACE;
    end
  end

endmodule
`default_nettype wire

FILE: design/dtok_scan.sv
`default_nettype none
module dtok_scan (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic         end_mark,
  input  wire dtok_pkg::class_t cls,
  output logic              res_free,
  dtok_out_if.source        res
);

  logic [dtok_pkg::POS_W-1:0] position, position_next;
  logic [dtok_pkg::IDX_W-1:0] start_pos, start_pos_next;
  logic [dtok_pkg::IDX_W-1:0] last_pos, last_pos_next;
  logic                       seen_token, seen_token_next;
  logic                       in_leading_space, in_leading_space_next;
  logic                       reported, reported_next;

  logic [dtok_pkg::IDX_W-1:0] idx;
  logic [dtok_pkg::LEN_W-1:0] len;
  logic                       note;

  assign res_free = !res.valid || res.ready;
  assign idx = position[dtok_pkg::IDX_W-1:0];
  assign len = dtok_pkg::LEN_W'(last_pos) - dtok_pkg::LEN_W'(start_pos)
               + dtok_pkg::LEN_W'(1);

  always_comb begin
    position_next         = position;
    start_pos_next        = start_pos;
    last_pos_next         = last_pos;
    seen_token_next       = seen_token;
    in_leading_space_next = in_leading_space;
    reported_next         = reported;
    note                  = 1'b0;
    if (end_mark) begin
      position_next         = '0;
      start_pos_next        = '0;
      last_pos_next         = '0;
      seen_token_next       = 1'b0;
      in_leading_space_next = 1'b1;
      reported_next         = 1'b0;
    end else if (!reported && (position < dtok_pkg::POS_W'(dtok_pkg::MAX_LEN))) begin
      position_next = position + dtok_pkg::POS_W'(1);
      unique case (cls.mode)
        dtok_pkg::MODE_TRIM: begin
          note = !cls.sp;
        end
        dtok_pkg::MODE_SPACE: begin
          if (!(in_leading_space && cls.sp)) begin
            in_leading_space_next = 1'b0;
            if (cls.sp) reported_next = 1'b1;
            else note = 1'b1;
          end
        end
        default: begin
          if (!cls.sp) begin
            if (cls.hit) reported_next = 1'b1;
            else note = 1'b1;
          end
        end
      endcase
      if (note) begin
        if (!seen_token) begin
          seen_token_next = 1'b1;
          start_pos_next  = idx;
        end
        last_pos_next = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      start_pos        <= '0;
      last_pos         <= '0;
      seen_token       <= 1'b0;
      in_leading_space <= 1'b1;
      reported         <= 1'b0;
    end else if (step) begin
      position         <= position_next;
      start_pos        <= start_pos_next;
      last_pos         <= last_pos_next;
      seen_token       <= seen_token_next;
      in_leading_space <= in_leading_space_next;
      reported         <= reported_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (step && end_mark) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && end_mark) begin
      res.token_found  <= seen_token;
      res.token_start  <= seen_token ? dtok_pkg::START_W'(start_pos) : '0;
      res.token_length <= seen_token ? dtok_pkg::LENGTH_W'(len) : '0;
      res.rest_valid   <= reported;
      res.rest_offset  <= reported ? dtok_pkg::REST_W'(position) : '0;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_delimiter_tokenizer.sv
module tb_delimiter_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import dtok_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int PRINT_CAP      = 50;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                found;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic                rest_v;
    logic [REST_W-1:0]   rest;
  } token_t;

  typedef enum logic [1:0] {ROW_CHAR, ROW_END, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [SET_W-1:0]     value;
    logic                 typed;
    token_t               want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SET_W-1:0]     cfg_data;

  dtok_in_if  chars();
  dtok_out_if tokens();

  delimiter_tokenizer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (chars),
    .tokens    (tokens)
  );

  always #5 clk = ~clk;

  token_t pending_tokens[$];
  int     errors;
  int     checked;
  int     reg_writes;
  int     strings;
  int     requests;
  int     scanned;
  bit     quiet;

  logic                cur_absent;
  logic [COUNT_W-1:0]  cur_count;
  logic [SET_W-1:0]    cur_set;

  logic [POS_W-1:0]    scan_pos;
  logic [START_W-1:0]  tok_first;
  logic [START_W-1:0]  tok_last;
  bit                  tok_seen;
  bit                  lead_blank;
  bit                  stopped;

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [CHAR_W-1:0] set_byte(input int k);
    return cur_set[k*8 +: 8];
  endfunction

  task automatic clear_scan();
    scan_pos   = '0;
    tok_first  = '0;
    tok_last   = '0;
    tok_seen   = 0;
    lead_blank = 1;
    stopped    = 0;
  endtask

  task automatic mark_token(input logic [START_W-1:0] idx);
    if (!tok_seen) begin
      tok_seen  = 1;
      tok_first = idx;
    end
    tok_last = idx;
  endtask

  task automatic scan_request(input logic [CHAR_W-1:0] c, input logic e,
                              output bit has_res, output token_t tok, output bit used);
    int                 n;
    logic [1:0]         mode;
    bit                 hit;
    logic [START_W-1:0] idx;
    has_res = 0;
    tok     = '0;
    used    = 1;
    if (e) begin
      has_res = 1;
      if (tok_seen) begin
        tok.found  = 1'b1;
        tok.start  = tok_first;
        tok.length = {1'b0, tok_last} - {1'b0, tok_first} + 17'd1;
      end
      if (stopped) begin
        tok.rest_v = 1'b1;
        tok.rest   = scan_pos;
      end
      clear_scan();
    end else if (stopped || scan_pos >= MAX_LEN) begin
      used = 0;
    end else begin
      n    = (cur_count > NUM_DELIMS) ? NUM_DELIMS : int'(cur_count);
      mode = cur_absent ? MODE_TRIM : MODE_SPACE;
      hit  = 0;
      for (int k = 0; k < n; k++) begin
        if (!cur_absent && !is_blank(set_byte(k))) mode = MODE_DELIM;
        if (c == set_byte(k)) hit = 1;
      end
      idx      = scan_pos[START_W-1:0];
      scan_pos = scan_pos + 1'b1;
      case (mode)
        MODE_TRIM: begin
          if (!is_blank(c)) mark_token(idx);
        end
        MODE_SPACE: begin
          if (!(lead_blank && is_blank(c))) begin
            lead_blank = 0;
            if (is_blank(c)) stopped = 1;
            else mark_token(idx);
          end
        end
        default: begin
          if (!is_blank(c)) begin
            if (hit) stopped = 1;
            else mark_token(idx);
          end
        end
      endcase
    end
  endtask

  function automatic int pick_pause();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input bit noise);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (noise || r < 15) return CHAR_W'($urandom_range(0, 255));
    if (r < 45) begin
      k = $urandom_range(0, 5);
      return (k == 5) ? 8'h20 : CHAR_W'(8'h09 + k);
    end
    if (r < 60) return set_byte($urandom_range(0, 3));
    return CHAR_W'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic token_t tk(input logic found, input logic [START_W-1:0] start,
                                input logic [LENGTH_W-1:0] length, input logic rest_v,
                                input logic [REST_W-1:0] rest);
    token_t t;
    t = '{found, start, length, rest_v, rest};
    return t;
  endfunction

  function automatic row_t ch(input logic [CHAR_W-1:0] c);
    row_t r;
    r = '{ROW_CHAR, CFG_DELIMS_ABSENT, {24'b0, c}, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t fin(input logic typed, input token_t want);
    row_t r;
    r = '{ROW_END, CFG_DELIMS_ABSENT, '0, typed, want};
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [SET_W-1:0] v);
    row_t r;
    r = '{ROW_REG, idx, v, 1'b0, '0};
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch on result %0d: %s got 'h%0h expected 'h%0h", checked, field, got, want);
  endtask

  task automatic send_request(input logic [CHAR_W-1:0] c, input logic e, input logic typed,
                              input token_t want, output bit used);
    bit     has_res;
    token_t tok;
    int     gap;
    @(negedge clk);
    chars.valid    <= 1'b1;
    chars.char_in  <= c;
    chars.end_mark <= e;
    do @(posedge clk); while (!chars.ready);
    scan_request(c, e, has_res, tok, used);
    if (has_res) pending_tokens.push_back(typed ? want : tok);
    requests++;
    if (used) scanned++;
    if (e) strings++;
    gap = pick_pause();
    if (gap > 0) begin
      @(negedge clk);
      chars.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold the sender until every result is back and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    chars.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SET_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELIMS_ABSENT: cur_absent = value[0];
      CFG_DELIM_COUNT:   cur_count  = value[COUNT_W-1:0];
      CFG_DELIM_SET:     cur_set    = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_mode(input logic absent, input logic [COUNT_W-1:0] count,
                          input logic [SET_W-1:0] bytes);
    logic [SET_W-1:0] junk;
    junk = $urandom();
    drain();
    write_reg(CFG_DELIMS_ABSENT, {junk[SET_W-1:1], absent});
    write_reg(CFG_DELIM_COUNT, {junk[SET_W-1:COUNT_W], count});
    write_reg(CFG_DELIM_SET, bytes);
  endtask

  initial begin
    int stall;
    tokens.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        tokens.ready <= 1'b0;
        stall--;
      end else begin
        tokens.ready <= 1'b1;
        stall = pick_pause();
      end
    end
  end

  initial begin
    token_t want;
    forever begin
      @(posedge clk);
      if (tokens.valid && tokens.ready) begin
        if (pending_tokens.size() == 0) begin
          report("result with none outstanding", 32'(tokens.token_found), 32'd0);
        end else begin
          want = pending_tokens.pop_front();
          if (tokens.token_found !== want.found)
            report("token_found", 32'(tokens.token_found), 32'(want.found));
          if (tokens.token_start !== want.start)
            report("token_start", 32'(tokens.token_start), 32'(want.start));
          if (tokens.token_length !== want.length)
            report("token_length", 32'(tokens.token_length), 32'(want.length));
          if (tokens.rest_valid !== want.rest_v)
            report("rest_valid", 32'(tokens.rest_valid), 32'(want.rest_v));
          if (tokens.rest_offset !== want.rest)
            report("rest_offset", 32'(tokens.rest_offset), 32'(want.rest));
          checked++;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((chars.valid && chars.ready) || (tokens.valid && tokens.ready)) idle = 0;
      else idle++;
    end
    $display("stalled for %0d cycles with %0d results outstanding",
             WATCHDOG_LIMIT, pending_tokens.size());
    $display("tb_delimiter_tokenizer NOT OK");
    $finish;
  end

  initial begin
    row_t             directed[$];
    bit               used;
    bit               noise;
    int               base;
    int               len;
    logic [SET_W-1:0] bytes;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    chars.valid    = 1'b0;
    chars.char_in  = '0;
    chars.end_mark = 1'b0;
    errors         = 0;
    checked        = 0;
    reg_writes     = 0;
    strings        = 0;
    requests       = 0;
    scanned        = 0;
    quiet          = 0;
    cur_absent     = 1'b1;
    cur_count      = '0;
    cur_set        = '0;
    clear_scan();

    directed = '{
      fin(1'b1, tk(1'b0, 16'd0, 17'd0, 1'b0, 17'd0)),
      reg_row(CFG_UNUSED, 32'hFFFF_FFFF),
      ch(8'h20), ch(8'h09), ch(8'h61), ch(8'h20), ch(8'hFF), ch(8'h0D),
      fin(1'b1, tk(1'b1, 16'd2, 17'd3, 1'b0, 17'd0)),
      reg_row(CFG_DELIMS_ABSENT, 32'h0),
      ch(8'h0B), ch(8'h00), ch(8'h0C), ch(8'h71),
      fin(1'b1, tk(1'b1, 16'd1, 17'd1, 1'b1, 17'd3)),
      reg_row(CFG_DELIM_COUNT, 32'h7),
      reg_row(CFG_DELIM_SET, 32'hFF00_202C),
      ch(8'h20), ch(8'h61), ch(8'h20), ch(8'h62), ch(8'hFF),
      fin(1'b1, tk(1'b1, 16'd1, 17'd3, 1'b1, 17'd5)),
      ch(8'h78),
      reg_row(CFG_DELIM_COUNT, 32'h1),
      ch(8'hFF), ch(8'h2C), ch(8'h7A),
      fin(1'b0, '0),
      reg_row(CFG_DELIM_SET, 32'h0A0D_0920),
      reg_row(CFG_DELIM_COUNT, 32'h4),
      ch(8'h0A), ch(8'h7A), ch(8'h3B),
      fin(1'b0, '0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        drain();
        write_reg(directed[i].reg_idx, directed[i].value);
      end else begin
        send_request(directed[i].value[CHAR_W-1:0], directed[i].kind == ROW_END,
                     directed[i].typed, directed[i].want, used);
      end
    end

    base = requests;
    while (requests - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 9))
          0: bytes = '0;
          1: bytes = '1;
          default: bytes = {pick_char(0), pick_char(0), pick_char(0), pick_char(0)};
        endcase
        set_mode($urandom_range(0, 3) == 0, COUNT_W'($urandom_range(0, 7)), bytes);
      end
      if ($urandom_range(0, 40) == 0) drain();
      if ($urandom_range(0, 9) == 0) quiet = !quiet;
      noise = ($urandom_range(0, 9) == 0);
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(11, 48);
      repeat (len) send_request(pick_char(noise), 1'b0, 1'b0, '0, used);
      send_request(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0, used);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("ran %0d strings, %0d requests (%0d scanned), %0d register writes",
             strings, requests, scanned, reg_writes);
    $display("compared %0d results, %0d mismatches", checked, errors);
    if (errors == 0 && pending_tokens.size() == 0) begin
      $display("tb_delimiter_tokenizer OK");
    end else begin
      $display("tb_delimiter_tokenizer NOT OK");
    end
    $finish;
  end

endmodule
